/* design/rsce_pkg.sv */
// Shared types, codes and keyword constants for the reply status/command extractor.
package rsce_pkg;

  localparam int unsigned WinLen = 9;
  localparam int unsigned KwStatusLen = 8;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0] CharFill = 8'h58;   // 'X'
  localparam logic [7:0] CharLower = 8'h78;  // 'x'
  localparam logic [7:0] CharComma = 8'h2c;

  localparam logic [7:0] KwCommand [WinLen] = '{
    8'h43, 8'h6f, 8'h6d, 8'h6d, 8'h61, 8'h6e, 8'h64, 8'h3a, 8'h20
  };
  localparam logic [7:0] KwStatus [KwStatusLen] = '{
    8'h53, 8'h74, 8'h61, 8'h74, 8'h75, 8'h73, 8'h3a, 8'h20
  };

  typedef enum logic [CfgIdxW-1:0] {
    RegGoodStatus = 3'd0,
    RegBatteryMin = 3'd1,
    RegIntervalLo = 3'd2,
    RegIntervalHi = 3'd3,
    RegIntervalEx = 3'd4,
    RegRebootCode = 3'd5,
    RegRetimeWin  = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    FuncByte = 1'b0,
    FuncEnd  = 1'b1
  } func_e;

  typedef struct packed {
    logic [5:0] clock_minute;
    logic [4:0] clock_hour;
    logic [6:0] battery_percent;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  bad_reply_count;
    logic        interval_updated;
    logic [7:0]  interval_now;
    logic        reboot_request;
    logic [15:0] command_value;
    logic [15:0] status_value;
    logic        status_ok;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t r;
    r.ok = 1'b1;
    r.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.nib = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

/* design/reply_status_command_extractor.sv */
// Reply scanner: keyword capture of status and command fields, end-of-reply decision.
//
// Takes one request per clock unless a held result blocks it: a received byte
// (tuser 0) or an end-of-reply marker (tuser 1). Bytes produce no output. Each
// end-of-reply produces one result. The request is taken into the input register,
// and the result register is loaded from it once any held result has been taken.
// The keyword window compare, capture, hex decode and interval decision each fit
// in the single logic stage between those registers, so the sustained rate is one
// request per cycle as long as results are taken. A held result blocks input only
// once the next end-of-reply reaches the input register; bytes ahead of it keep
// flowing. Both field buffers hold CAPTURE_LEN characters; longer fields are cut
// at that length.
module reply_status_command_extractor #(
  parameter int unsigned CAPTURE_LEN = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [7:0] rx_byte, [14:8] battery_percent, [19:15] clock_hour,
  // [25:20] clock_minute, [31:26] zero
  input  logic [31:0]                  s_axis_tdata_i,
  // [0] func
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [0] status_ok, [16:1] status_value, [32:17] command_value, [33] reboot_request,
  // [41:34] interval_now, [42] interval_updated, [50:43] bad_reply_count, [55:51] zero
  output logic [55:0]                  m_axis_tdata_o,
  input  logic                         cfg_we_i,
  input  logic [rsce_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rsce_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(CAPTURE_LEN + 1);
  localparam int unsigned AW = $clog2(CAPTURE_LEN);
  localparam logic [IdxW-1:0] LenIdx = IdxW'(CAPTURE_LEN);
  localparam logic [IdxW:0] LenIdxW = (IdxW + 1)'(CAPTURE_LEN);

  // configuration
  logic [15:0] good_status_q;
  logic [6:0]  battery_min_q;
  logic [7:0]  interval_lo_q;
  logic [7:0]  interval_hi_q;
  logic [7:0]  interval_ex_q;
  logic [3:0]  reboot_code_q;
  logic [10:0] retime_win_q;

  // input register
  logic                 in_valid_q;
  rsce_pkg::func_e      in_func_q;
  rsce_pkg::in_item_t   in_item_q;
  logic                 fire;

  // scan state
  logic [7:0]      win_q [rsce_pkg::WinLen];
  logic [7:0]      win_d [rsce_pkg::WinLen];
  logic [7:0]      win_sh [rsce_pkg::WinLen];
  logic [7:0]      sbuf_q [CAPTURE_LEN];
  logic [7:0]      sbuf_d [CAPTURE_LEN];
  logic [7:0]      cbuf_q [CAPTURE_LEN];
  logic [7:0]      cbuf_d [CAPTURE_LEN];
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW:0]   idx_next;
  logic            cap_sts_q, cap_sts_d;
  logic            cap_cmd_q, cap_cmd_d;
  logic            cmd_done_q, cmd_done_d;
  logic            kw_cmd_hit, kw_sts_hit;

  // persistent state
  logic [7:0] interval_q, interval_d;
  logic [4:0] stamp_hour_q, stamp_hour_d;
  logic [5:0] stamp_min_q, stamp_min_d;
  logic [7:0] tally_q, tally_d;

  // decision
  logic [15:0]        sts_val, cmd_val;
  logic               sts_go, cmd_go;
  rsce_pkg::hex_digit_t sdig, cdig;
  logic [7:0]         want;
  logic               sts_ok, reboot, updated, want_ok;
  logic signed [12:0] hour_diff, min_diff, time_diff, win_pos, win_neg;

  // output register
  logic                out_valid_q;
  rsce_pkg::out_item_t out_item_q, out_item_d;

  assign fire = in_valid_q &&
                (in_func_q == rsce_pkg::FuncByte || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_item_q};

  // hex decode of both buffers
  always_comb begin
    sts_val = 16'd0;
    cmd_val = 16'd0;
    sts_go = 1'b1;
    cmd_go = 1'b1;
    sdig = '0;
    cdig = '0;
    for (int unsigned i = 0; i < CAPTURE_LEN; i++) begin
      sdig = rsce_pkg::hex_digit(sbuf_q[i]);
      cdig = rsce_pkg::hex_digit(cbuf_q[i]);
      if (sts_go && sdig.ok) begin
        sts_val = {sts_val[11:0], sdig.nib};
      end else begin
        sts_go = 1'b0;
      end
      if (cmd_go && cdig.ok) begin
        cmd_val = {cmd_val[11:0], cdig.nib};
      end else begin
        cmd_go = 1'b0;
      end
    end
  end

  always_comb begin
    want = cmd_val[11:4];
    sts_ok = (sts_val == good_status_q);
    reboot = sts_ok && (cmd_val[3:0] == reboot_code_q);
    want_ok = (in_item_q.battery_percent > battery_min_q) && (want >= interval_lo_q) &&
              (want <= interval_hi_q) && (want != interval_ex_q);
    hour_diff = 13'($signed({1'b0, in_item_q.clock_hour})) -
                13'($signed({1'b0, stamp_hour_q}));
    min_diff  = 13'($signed({1'b0, in_item_q.clock_minute})) -
                13'($signed({1'b0, stamp_min_q}));
    // times 60 as 64 - 4
    time_diff = (hour_diff <<< 6) - (hour_diff <<< 2) + min_diff;
    win_pos = $signed({2'b00, retime_win_q});
    win_neg = -win_pos;
    updated = sts_ok && want_ok &&
              (time_diff > win_pos || time_diff < win_neg || want != interval_q);
  end

  // advance the window by the incoming byte
  always_comb begin
    for (int unsigned i = 0; i < rsce_pkg::WinLen - 1; i++) begin
      win_sh[i] = win_q[i + 1];
    end
    win_sh[rsce_pkg::WinLen - 1] = in_item_q.rx_byte;
  end

  always_comb begin
    kw_cmd_hit = 1'b1;
    for (int unsigned i = 0; i < rsce_pkg::WinLen; i++) begin
      if (win_sh[i] != rsce_pkg::KwCommand[i]) begin
        kw_cmd_hit = 1'b0;
      end
    end
    kw_sts_hit = 1'b1;
    for (int unsigned i = 0; i < rsce_pkg::KwStatusLen; i++) begin
      if (win_sh[i + 1] != rsce_pkg::KwStatus[i]) begin
        kw_sts_hit = 1'b0;
      end
    end
  end

  // next scan and persistent state
  always_comb begin
    win_d = win_sh;
    sbuf_d = sbuf_q;
    cbuf_d = cbuf_q;
    idx_d = idx_q;
    idx_next = {1'b0, idx_q} + (IdxW + 1)'(1);
    cap_sts_d = cap_sts_q;
    cap_cmd_d = cap_cmd_q;
    cmd_done_d = cmd_done_q;
    interval_d = interval_q;
    stamp_hour_d = stamp_hour_q;
    stamp_min_d = stamp_min_q;
    tally_d = tally_q;
    out_item_d = out_item_q;

    if (in_func_q == rsce_pkg::FuncByte) begin
      if (in_item_q.rx_byte == rsce_pkg::CharComma && cap_cmd_d) begin
        if (idx_d < LenIdx) cbuf_d[idx_d[AW-1:0]] = 8'd0;
        idx_next = {1'b0, idx_d} + (IdxW + 1)'(1);
        if (idx_next < LenIdxW) cbuf_d[idx_next[AW-1:0]] = 8'd0;
        cmd_done_d = 1'b1;
        cap_cmd_d = 1'b0;
        idx_d = '0;
      end
      if (in_item_q.rx_byte == rsce_pkg::CharComma && cap_sts_d) begin
        if (idx_d < LenIdx) sbuf_d[idx_d[AW-1:0]] = 8'd0;
        idx_next = {1'b0, idx_d} + (IdxW + 1)'(1);
        if (idx_next < LenIdxW) sbuf_d[idx_next[AW-1:0]] = 8'd0;
        cap_sts_d = 1'b0;
        idx_d = '0;
      end
      if (cap_cmd_d && idx_d < LenIdx) begin
        cbuf_d[idx_d[AW-1:0]] = in_item_q.rx_byte;
        idx_d = idx_d + IdxW'(1);
      end
      if (cap_sts_d && idx_d < LenIdx) begin
        sbuf_d[idx_d[AW-1:0]] = in_item_q.rx_byte;
        idx_d = idx_d + IdxW'(1);
      end
      if (kw_cmd_hit) cap_cmd_d = 1'b1;
      if (kw_sts_hit) cap_sts_d = 1'b1;
    end else begin
      if (!sts_ok) tally_d = tally_q + 8'd1;
      if (updated) begin
        interval_d = want;
        stamp_hour_d = in_item_q.clock_hour;
        stamp_min_d = in_item_q.clock_minute;
      end
      out_item_d.status_ok = sts_ok;
      out_item_d.status_value = sts_val;
      out_item_d.command_value = cmd_val;
      out_item_d.reboot_request = reboot;
      out_item_d.interval_now = interval_d;
      out_item_d.interval_updated = updated;
      out_item_d.bad_reply_count = tally_d;
      // drop the per-reply scan state
      for (int unsigned i = 0; i < rsce_pkg::WinLen; i++) begin
        win_d[i] = rsce_pkg::CharFill;
      end
      for (int unsigned i = 0; i < CAPTURE_LEN; i++) begin
        sbuf_d[i] = (i + 1 < CAPTURE_LEN) ? rsce_pkg::CharLower : 8'd0;
        cbuf_d[i] = (i + 1 < CAPTURE_LEN) ? rsce_pkg::CharLower : 8'd0;
      end
      idx_d = '0;
      cap_sts_d = 1'b0;
      cap_cmd_d = 1'b0;
      cmd_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_status_q <= 16'h0084;
      battery_min_q <= 7'd20;
      interval_lo_q <= 8'd2;
      interval_hi_q <= 8'd30;
      interval_ex_q <= 8'd15;
      reboot_code_q <= 4'd7;
      retime_win_q  <= 11'd60;
    end else if (cfg_we_i) begin
      case (rsce_pkg::cfg_reg_e'(cfg_index_i))
        rsce_pkg::RegGoodStatus: good_status_q <= cfg_data_i;
        rsce_pkg::RegBatteryMin: battery_min_q <= cfg_data_i[6:0];
        rsce_pkg::RegIntervalLo: interval_lo_q <= cfg_data_i[7:0];
        rsce_pkg::RegIntervalHi: interval_hi_q <= cfg_data_i[7:0];
        rsce_pkg::RegIntervalEx: interval_ex_q <= cfg_data_i[7:0];
        rsce_pkg::RegRebootCode: reboot_code_q <= cfg_data_i[3:0];
        rsce_pkg::RegRetimeWin:  retime_win_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_func_q <= rsce_pkg::FuncByte;
      in_item_q <= '0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
      if (s_axis_tvalid_i) begin
        in_func_q <= rsce_pkg::func_e'(s_axis_tuser_i);
        in_item_q <= rsce_pkg::in_item_t'(s_axis_tdata_i[25:0]);
      end
    end
  end

  // scan state; bytes after the command field has closed leave it untouched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < rsce_pkg::WinLen; i++) begin
        win_q[i] <= rsce_pkg::CharFill;
      end
      for (int unsigned i = 0; i < CAPTURE_LEN; i++) begin
        sbuf_q[i] <= (i + 1 < CAPTURE_LEN) ? rsce_pkg::CharLower : 8'd0;
        cbuf_q[i] <= (i + 1 < CAPTURE_LEN) ? rsce_pkg::CharLower : 8'd0;
      end
      idx_q <= '0;
      cap_sts_q <= 1'b0;
      cap_cmd_q <= 1'b0;
      cmd_done_q <= 1'b0;
      interval_q <= '0;
      stamp_hour_q <= '0;
      stamp_min_q <= '0;
      tally_q <= '0;
    end else if (fire && !(in_func_q == rsce_pkg::FuncByte && cmd_done_q)) begin
      win_q <= win_d;
      sbuf_q <= sbuf_d;
      cbuf_q <= cbuf_d;
      idx_q <= idx_d;
      cap_sts_q <= cap_sts_d;
      cap_cmd_q <= cap_cmd_d;
      cmd_done_q <= cmd_done_d;
      interval_q <= interval_d;
      stamp_hour_q <= stamp_hour_d;
      stamp_min_q <= stamp_min_d;
      tally_q <= tally_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_item_q <= '0;
    end else if (fire && in_func_q == rsce_pkg::FuncEnd) begin
      out_valid_q <= 1'b1;
      out_item_q <= out_item_d;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the reply status/command extractor.
module tb_top;
  import rsce_pkg::*;

  localparam int unsigned CaptureLen = 4;
  localparam int NumPhases = 6;
  localparam int PhaseItems = 110;
  localparam int PhaseReplies = 8;
  localparam int LongHold = 300;
  localparam int DrainCycles = 8;
  localparam int StallLimit = 2000;

  typedef logic [CaptureLen-1:0][7:0] field_chars_t;

  // Tracks the scan state of the block and holds the decisions still owed by it.
  class reply_checker;
    logic [15:0] good_code;
    logic [6:0]  batt_min;
    logic [7:0]  ivl_lo;
    logic [7:0]  ivl_hi;
    logic [7:0]  ivl_ex;
    logic [3:0]  reboot_nib;
    logic [10:0] retime_min;

    logic [7:0]   window [WinLen];
    field_chars_t sts_chars;
    field_chars_t cmd_chars;
    int unsigned  cap_idx;
    bit           in_status;
    bit           in_command;
    bit           command_closed;

    logic [7:0] ivl_held;
    logic [4:0] stamp_h;
    logic [5:0] stamp_m;
    logic [7:0] bad_count;

    string kw_command = "Command: ";
    string kw_status = "Status: ";

    out_item_t pending_replies [$];
    int errors;

    function new();
      good_code = 16'h0084;
      batt_min = 7'd20;
      ivl_lo = 8'd2;
      ivl_hi = 8'd30;
      ivl_ex = 8'd15;
      reboot_nib = 4'd7;
      retime_min = 11'd60;
      ivl_held = '0;
      stamp_h = '0;
      stamp_m = '0;
      bad_count = '0;
      errors = 0;
      clear_scan();
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] val);
      case (idx)
        RegGoodStatus: good_code = val;
        RegBatteryMin: batt_min = val[6:0];
        RegIntervalLo: ivl_lo = val[7:0];
        RegIntervalHi: ivl_hi = val[7:0];
        RegIntervalEx: ivl_ex = val[7:0];
        RegRebootCode: reboot_nib = val[3:0];
        RegRetimeWin:  retime_min = val[10:0];
        default: ;
      endcase
    endfunction

    function void clear_scan();
      for (int i = 0; i < WinLen; i++) window[i] = CharFill;
      for (int i = 0; i < CaptureLen; i++) begin
        sts_chars[i] = (i + 1 < CaptureLen) ? CharLower : 8'h00;
        cmd_chars[i] = (i + 1 < CaptureLen) ? CharLower : 8'h00;
      end
      cap_idx = 0;
      in_status = 1'b0;
      in_command = 1'b0;
      command_closed = 1'b0;
    endfunction

    // Terminate a field at the shared index and the slot after it.
    function void close_field(bit on_cmd);
      if (cap_idx < CaptureLen) begin
        if (on_cmd) cmd_chars[cap_idx] = 8'h00;
        else sts_chars[cap_idx] = 8'h00;
      end
      if (cap_idx + 1 < CaptureLen) begin
        if (on_cmd) cmd_chars[cap_idx + 1] = 8'h00;
        else sts_chars[cap_idx + 1] = 8'h00;
      end
    endfunction

    function void store_into(bit on_cmd, logic [7:0] c);
      if (cap_idx < CaptureLen) begin
        if (on_cmd) cmd_chars[cap_idx] = c;
        else sts_chars[cap_idx] = c;
        cap_idx++;
      end
    endfunction

    function logic [15:0] decode_field(field_chars_t f);
      logic [15:0] v;
      logic [3:0]  nib;
      bit          stop;
      v = '0;
      stop = 1'b0;
      for (int i = 0; i < CaptureLen; i++) begin
        if (!stop) begin
          if (f[i] >= "0" && f[i] <= "9") nib = 4'(f[i] - "0");
          else if (f[i] >= "a" && f[i] <= "f") nib = 4'(f[i] - "a" + 10);
          else if (f[i] >= "A" && f[i] <= "F") nib = 4'(f[i] - "A" + 10);
          else stop = 1'b1;
          if (!stop) v = {v[11:0], nib};
        end
      end
      return v;
    endfunction

    function void note_request(func_e func, in_item_t item);
      logic [7:0]  c;
      logic [15:0] sts;
      logic [15:0] cmd;
      logic [7:0]  want;
      out_item_t   exp;
      bit          hit;
      int          gap_min;
      int          win;
      if (func == FuncByte) begin
        if (command_closed) return;
        c = item.rx_byte;
        for (int i = 0; i < WinLen - 1; i++) window[i] = window[i + 1];
        window[WinLen - 1] = c;
        if (c == CharComma && in_command) begin
          close_field(1'b1);
          command_closed = 1'b1;
          in_command = 1'b0;
          cap_idx = 0;
        end
        if (c == CharComma && in_status) begin
          close_field(1'b0);
          in_status = 1'b0;
          cap_idx = 0;
        end
        if (in_command) store_into(1'b1, c);
        if (in_status) store_into(1'b0, c);
        hit = 1'b1;
        for (int i = 0; i < WinLen; i++) if (window[i] != kw_command[i]) hit = 1'b0;
        if (hit) in_command = 1'b1;
        // status keyword sits in the newest eight bytes
        hit = 1'b1;
        for (int i = 0; i < WinLen - 1; i++) if (window[i + 1] != kw_status[i]) hit = 1'b0;
        if (hit) in_status = 1'b1;
        return;
      end
      sts = decode_field(sts_chars);
      cmd = decode_field(cmd_chars);
      want = cmd[11:4];
      exp = '0;
      exp.status_ok = (sts == good_code);
      exp.status_value = sts;
      exp.command_value = cmd;
      if (!exp.status_ok) begin
        bad_count++;
      end else begin
        exp.reboot_request = (cmd[3:0] == reboot_nib);
        if (item.battery_percent > batt_min && want >= ivl_lo && want <= ivl_hi &&
            want != ivl_ex) begin
          gap_min = (int'(item.clock_hour) - int'(stamp_h)) * 60 +
                    (int'(item.clock_minute) - int'(stamp_m));
          win = int'(retime_min);
          if (gap_min > win || gap_min < -win || want != ivl_held) begin
            ivl_held = want;
            stamp_h = item.clock_hour;
            stamp_m = item.clock_minute;
            exp.interval_updated = 1'b1;
          end
        end
      end
      exp.interval_now = ivl_held;
      exp.bad_reply_count = bad_count;
      pending_replies.push_back(exp);
      clear_scan();
    endfunction

    function void compare_field(string what, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
      end
    endfunction

    function void check_reply(out_item_t got);
      out_item_t exp;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual %h", $time, got);
        return;
      end
      exp = pending_replies.pop_front();
      compare_field("status_ok", 16'(exp.status_ok), 16'(got.status_ok));
      compare_field("status_value", exp.status_value, got.status_value);
      compare_field("command_value", exp.command_value, got.command_value);
      compare_field("reboot_request", 16'(exp.reboot_request), 16'(got.reboot_request));
      compare_field("interval_now", 16'(exp.interval_now), 16'(got.interval_now));
      compare_field("interval_updated", 16'(exp.interval_updated),
                    16'(got.interval_updated));
      compare_field("bad_reply_count", 16'(exp.bad_reply_count), 16'(got.bad_reply_count));
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [31:0]         s_axis_tdata_i;
  logic                s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [55:0]         m_axis_tdata_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  reply_checker sb;
  logic [7:0]   reply_bytes [$];
  bit           src_gaps_on;
  bit           sink_stalls_on;
  bit           hold_sink;
  int           sink_stall_left;
  int           phase_items;
  int           phase_replies;
  int           quiet_cycles;

  reply_status_command_extractor #(
    .CAPTURE_LEN(CaptureLen)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    m_axis_tready_i = 1'b0;
    sink_stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready_i = 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      if (sink_stall_left > 0) begin
        sink_stall_left--;
        m_axis_tready_i = 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        sink_stall_left = $urandom_range(1, 12) - 1;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_reply(m_axis_tdata_o[$bits(out_item_t)-1:0]);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_request(input func_e func, input in_item_t item);
    int gap;
    @(negedge clk_i);
    if (src_gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = func;
    s_axis_tdata_i = 32'(item);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(func, item);
    phase_items++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Drop valid, wait out every owed result, then let the pipeline settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(input int phase);
    logic [15:0] vals [7];
    vals[0] = 16'($urandom);
    vals[1] = 16'($urandom_range(0, 100));
    vals[2] = 16'($urandom_range(0, 40));
    vals[3] = 16'($urandom_range(vals[2], 255));
    vals[4] = 16'($urandom_range(0, 255));
    vals[5] = 16'($urandom_range(0, 15));
    vals[6] = 16'($urandom_range(0, 1439));
    case (phase)
      2: vals = '{16'h0000, 16'd0, 16'd0, 16'd0, 16'd255, 16'd0, 16'd0};
      3: vals = '{16'hFFFF, 16'd100, 16'd0, 16'd255, 16'd255, 16'd15, 16'd1439};
      4: begin
        vals[2] = 16'd255;
        vals[3] = 16'd255;
        vals[4] = 16'd0;
      end
      default: ;
    endcase
    for (int i = 0; i < 7; i++) write_reg(cfg_reg_e'(i), vals[i]);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) reply_bytes.push_back(s[i]);
  endtask

  task automatic add_junk(input int n, input bit any_byte);
    for (int i = 0; i < n; i++) begin
      if (any_byte || $urandom_range(0, 3) == 0) reply_bytes.push_back(8'($urandom));
      else reply_bytes.push_back(8'($urandom_range(32, 126)));
    end
  endtask

  // Digits beyond the fourth come out as leading zeros.
  task automatic add_hex(input logic [15:0] v, input int ndig);
    logic [3:0] nib;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = (i < 4) ? v[4*i +: 4] : 4'h0;
      if (nib < 10) reply_bytes.push_back(8'("0" + nib));
      else if ($urandom_range(0, 1) == 0) reply_bytes.push_back(8'("a" + nib - 10));
      else reply_bytes.push_back(8'("A" + nib - 10));
    end
  endtask

  function automatic int hex_len(input logic [15:0] v);
    if (v[15:12] != 0) return 4;
    if (v[11:8] != 0) return 3;
    if (v[7:4] != 0) return 2;
    return 1;
  endfunction

  function automatic logic [15:0] pick_command();
    logic [7:0] want;
    logic [3:0] nib;
    logic [3:0] top;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 60 && sb.ivl_lo <= sb.ivl_hi) want = 8'($urandom_range(sb.ivl_lo, sb.ivl_hi));
    else if (r < 75) want = sb.ivl_held;
    else want = 8'($urandom);
    nib = ($urandom_range(0, 1) == 0) ? sb.reboot_nib : 4'($urandom);
    top = ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom);
    return {top, want, nib};
  endfunction

  function automatic in_item_t random_end_item();
    in_item_t item;
    item = 26'($urandom);
    if ($urandom_range(0, 9) == 0) item.battery_percent = 7'($urandom_range(101, 127));
    else item.battery_percent = 7'($urandom_range(0, 100));
    if ($urandom_range(0, 2) == 0) begin
      // land near the last stamp so the re-time window matters
      item.clock_hour = sb.stamp_h + 5'($urandom_range(0, 1));
      item.clock_minute = 6'($urandom_range(0, 59));
    end else begin
      if ($urandom_range(0, 9) == 0) item.clock_hour = 5'($urandom_range(24, 31));
      else item.clock_hour = 5'($urandom_range(0, 23));
      if ($urandom_range(0, 9) == 0) item.clock_minute = 6'($urandom_range(60, 63));
      else item.clock_minute = 6'($urandom_range(0, 59));
    end
    return item;
  endfunction

  task automatic send_bytes();
    in_item_t item;
    foreach (reply_bytes[i]) begin
      item = 26'($urandom);
      item.rx_byte = reply_bytes[i];
      push_request(FuncByte, item);
    end
    reply_bytes.delete();
  endtask

  task automatic build_reply();
    logic [15:0] sts;
    logic [15:0] cmd;
    int          k;
    sts = ($urandom_range(0, 4) != 0) ? sb.good_code : 16'($urandom);
    cmd = pick_command();
    k = $urandom_range(0, 99);
    if (k < 55) begin
      add_junk($urandom_range(0, 3), 1'b0);
      add_text("Status: ");
      add_hex(sts, hex_len(sts) + $urandom_range(0, 4 - hex_len(sts)));
      if ($urandom_range(0, 9) == 0) add_text("g");
      add_text(",");
      add_junk($urandom_range(0, 2), 1'b0);
      add_text("Command: ");
      add_hex(cmd, hex_len(cmd) + $urandom_range(0, 4 - hex_len(cmd)));
      add_text(",");
      // anything after the command field must be ignored
      if ($urandom_range(0, 3) == 0) add_text("Status: 1,");
      add_junk($urandom_range(0, 3), 1'b0);
    end else if (k < 65) begin
      add_text("Command: ");
      add_hex(cmd, hex_len(cmd));
      add_text(",");
      add_junk($urandom_range(0, 1), 1'b0);
      add_text("Status: ");
      add_hex(sts, hex_len(sts));
      add_text(",");
    end else if (k < 73) begin
      // second keyword arrives while the first field is still open
      if ($urandom_range(0, 1) == 0) begin
        add_text("Status: ");
        add_hex(sts, $urandom_range(0, 2));
        add_text("Command: ");
        add_hex(cmd, $urandom_range(1, 3));
      end else begin
        add_text("Command: ");
        add_hex(cmd, $urandom_range(0, 2));
        add_text("Status: ");
        add_hex(sts, $urandom_range(1, 3));
      end
      add_text(",");
      add_junk($urandom_range(0, 3), 1'b0);
    end else if (k < 81) begin
      add_text("Status: ");
      add_hex(16'($urandom), $urandom_range(5, 7));
      add_text(",");
      add_text("Command: ");
      if ($urandom_range(0, 1) == 0) add_hex(16'($urandom), $urandom_range(5, 7));
      else add_junk($urandom_range(5, 7), 1'b0);
      add_text(",");
    end else if (k < 88) begin
      add_text("Status: ");
      add_hex(sts, hex_len(sts));
      if ($urandom_range(0, 1) == 0) add_text(",");
      add_text("Command: ");
      add_hex(cmd, hex_len(cmd));
      add_junk($urandom_range(0, 3), 1'b0);
    end else if (k < 94) begin
      case ($urandom_range(0, 3))
        0: add_text("Statu: ");
        1: add_text("status: ");
        2: add_text("Comand: ");
        default: add_text("Command:");
      endcase
      add_hex(cmd, hex_len(cmd));
      add_text(",");
    end else begin
      add_junk($urandom_range(0, 12), 1'b1);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = FuncByte;
    cfg_we_i = 1'b0;
    cfg_index_i = RegGoodStatus;
    cfg_data_i = '0;
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    hold_sink = 1'b0;
    quiet_cycles = 0;
    phase_items = 0;
    phase_replies = 0;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // end of reply on untouched buffers, with out-of-range clock and battery
    push_request(FuncEnd, {6'd63, 5'd31, 7'd127, 8'hFF});
    add_text("Status: 84,Command: 1e7,");
    send_bytes();
    push_request(FuncEnd, {6'd0, 5'd0, 7'd100, 8'h00});

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        drain();
        configure(phase);
      end
      src_gaps_on = (phase < NumPhases - 1);
      sink_stalls_on = (phase < NumPhases - 1);
      if (phase == 3) hold_sink = 1'b1;
      phase_items = 0;
      phase_replies = 0;
      while (phase_items < PhaseItems || phase_replies < PhaseReplies) begin
        build_reply();
        send_bytes();
        push_request(FuncEnd, random_end_item());
        phase_replies++;
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
